/* sv/grd_pkg.sv */
package grd_pkg;

    localparam int unsigned SQ_STEPS  = 30;
    localparam int unsigned DIV_STEPS = 15;
    localparam int unsigned PIPE_LEN  = 4 + SQ_STEPS + DIV_STEPS + 1 + 6;

    localparam logic [14:0] ROUGH_MAX = 15'd16384;

    typedef enum logic [1:0] {
        ST_OUTWARD  = 2'd0,
        ST_ABSORBED = 2'd1,
        ST_ZERO     = 2'd2
    } status_t;

    // Per-item data that travels beside the root and quotient pipelines.
    typedef struct packed {
        logic [2:0][15:0] mag;
        logic [2:0]       neg;
        logic [2:0][15:0] nrm;
        logic [2:0][15:0] jit;
        logic             zero;
    } side_t;

endpackage

/* sv/glossy_reflection_direction_top.sv */
// Throughput: one beat per cycle; the 30-stage square root retires one root
// bit per stage, and the 16-stage dividers load in their first stage and then
// retire one quotient bit per stage.
// The whole pipeline holds while a result waits and the output is stalled.
// Reset clears all valid bits and sets roughness to zero.
module glossy_reflection_direction_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic signed [15:0] jitter_x,
    input  logic signed [15:0] jitter_y,
    input  logic signed [15:0] jitter_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [14:0]        roughness,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic [1:0]         status
);
    import grd_pkg::*;

    logic        en;
    logic [14:0] rough_reg;
    logic        vld_reg [PIPE_LEN];

    assign en        = !(vld_reg[PIPE_LEN-1] && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;
    assign out_valid = vld_reg[PIPE_LEN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rough_reg <= '0;
        end
        else if (cfg_valid)
        begin
            rough_reg <= (roughness > ROUGH_MAX) ? ROUGH_MAX : roughness;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LEN; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_LEN; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Stage 1: magnitude of the largest direction component.
    logic signed [15:0] din [3];
    logic [15:0]        dmag [3];
    logic [15:0]        max_next;
    logic signed [15:0] d1_reg [3];
    logic signed [15:0] n1_reg [3];
    logic signed [15:0] j1_reg [3];
    logic [15:0]        max1_reg;

    assign din[0] = dir_x;
    assign din[1] = dir_y;
    assign din[2] = dir_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dmag[i] = din[i][15] ? 16'(-din[i]) : 16'(din[i]);
        end
        max_next = dmag[0];
        if (dmag[1] > max_next)
        begin
            max_next = dmag[1];
        end
        if (dmag[2] > max_next)
        begin
            max_next = dmag[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i] <= din[i];
            end
            n1_reg[0] <= normal_x;
            n1_reg[1] <= normal_y;
            n1_reg[2] <= normal_z;
            j1_reg[0] <= jitter_x;
            j1_reg[1] <= jitter_y;
            j1_reg[2] <= jitter_z;
            max1_reg  <= max_next;
        end
    end

    // Stage 2: scale by a power of two so the largest component reaches 2^14.
    logic [3:0]         sh;
    logic signed [16:0] d2_reg [3];
    logic signed [15:0] n2_reg [3];
    logic signed [15:0] j2_reg [3];
    logic               zero2_reg;

    always_comb
    begin
        sh = '0;
        for (int b = 0; b < 14; b++)
        begin
            if (max1_reg[b])
            begin
                sh = 4'(14 - b);
            end
        end
        if (max1_reg[15:14] != 2'b00)
        begin
            sh = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d2_reg[i] <= 17'(d1_reg[i]) <<< sh;
                n2_reg[i] <= n1_reg[i];
                j2_reg[i] <= j1_reg[i];
            end
            zero2_reg <= (max1_reg == '0);
        end
    end

    // Stage 3: squares and magnitudes.
    logic signed [33:0] sq_full [3];
    logic [30:0]        sq3_reg [3];
    side_t              side3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_full[i] = 34'(d2_reg[i]) * 34'(d2_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq3_reg[i]         <= sq_full[i][30:0];
                side3_reg.mag[i]   <= d2_reg[i][16] ? 16'(-d2_reg[i]) : d2_reg[i][15:0];
                side3_reg.neg[i]   <= d2_reg[i][16];
                side3_reg.nrm[i]   <= n2_reg[i];
                side3_reg.jit[i]   <= j2_reg[i];
            end
            side3_reg.zero <= zero2_reg;
        end
    end

    // Stage 4: squared length.
    logic [31:0] len2_reg;
    side_t       side4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len2_reg  <= 32'(sq3_reg[0]) + 32'(sq3_reg[1]) + 32'(sq3_reg[2]);
            side4_reg <= side3_reg;
        end
    end

    // Square root, with the side data delayed alongside.
    logic [29:0] root;
    side_t       side_sq_reg [SQ_STEPS];

    grd_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (len2_reg),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_sq_reg[0] <= side4_reg;
            for (int i = 1; i < SQ_STEPS; i++)
            begin
                side_sq_reg[i] <= side_sq_reg[i-1];
            end
        end
    end

    // Division of each magnitude by the length.
    logic [14:0] quot [3];
    side_t       side_dv_reg [DIV_STEPS+1];

    for (genvar c = 0; c < 3; c++) begin : g_div
        grd_div u_div (
            .clk  (clk),
            .en   (en),
            .mag  (side_sq_reg[SQ_STEPS-1].mag[c]),
            .m    (root),
            .quot (quot[c])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dv_reg[0] <= side_sq_reg[SQ_STEPS-1];
            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                side_dv_reg[i] <= side_dv_reg[i-1];
            end
        end
    end

    // Stage E: signed unit components, dot terms and jitter products.
    side_t              sd;
    logic signed [15:0] u_next [3];
    logic signed [15:0] ue_reg [3];
    logic signed [31:0] pe_reg [3];
    logic signed [31:0] je_reg [3];
    logic signed [15:0] ne_reg [3];
    logic               zeroe_reg;

    assign sd = side_dv_reg[DIV_STEPS];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = sd.neg[i] ? -$signed({1'b0, quot[i]}) : $signed({1'b0, quot[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ue_reg[i] <= u_next[i];
                pe_reg[i] <= 32'(u_next[i]) * 32'($signed(sd.nrm[i]));
                je_reg[i] <= 32'($signed(sd.jit[i])) * 32'($signed({1'b0, rough_reg}));
                ne_reg[i] <= $signed(sd.nrm[i]);
            end
            zeroe_reg <= sd.zero;
        end
    end

    // Stage F: reflection coefficient and rounded jitter.
    logic signed [33:0] dot;
    logic signed [19:0] kf_reg;
    logic signed [17:0] jf_reg [3];
    logic signed [15:0] uf_reg [3];
    logic signed [15:0] nf_reg [3];
    logic               zerof_reg;

    assign dot = 34'(pe_reg[0]) + 34'(pe_reg[1]) + 34'(pe_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kf_reg <= 20'((dot + 34'sd8192) >>> 14);
            for (int i = 0; i < 3; i++)
            begin
                jf_reg[i] <= 18'((je_reg[i] + 32'sd8192) >>> 14);
                uf_reg[i] <= ue_reg[i];
                nf_reg[i] <= ne_reg[i];
            end
            zerof_reg <= zeroe_reg;
        end
    end

    // Stage G: normal times coefficient.
    logic signed [35:0] tg_reg [3];
    logic signed [17:0] jg_reg [3];
    logic signed [15:0] ug_reg [3];
    logic signed [15:0] ng_reg [3];
    logic               zerog_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tg_reg[i] <= 36'(nf_reg[i]) * 36'(kf_reg);
                jg_reg[i] <= jf_reg[i];
                ug_reg[i] <= uf_reg[i];
                ng_reg[i] <= nf_reg[i];
            end
            zerog_reg <= zerof_reg;
        end
    end

    // Stage H: reflected and jittered direction.
    logic signed [23:0] refl [3];
    logic signed [25:0] sh_reg [3];
    logic signed [15:0] nh_reg [3];
    logic               zeroh_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // Twice the product scaled by 2^-14, rounded: the product rounded at 13 bits.
            refl[i] = 24'((tg_reg[i] + 36'sd4096) >>> 13);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sh_reg[i] <= 26'(ug_reg[i]) - 26'(refl[i]) + 26'(jg_reg[i]);
                nh_reg[i] <= ng_reg[i];
            end
            zeroh_reg <= zerog_reg;
        end
    end

    // Stage I: side terms and rounded, saturated outputs.
    logic signed [26:0] rnd [3];
    logic signed [15:0] sat [3];
    logic signed [41:0] si_reg [3];
    logic signed [15:0] oi_reg [3];
    logic               zeroi_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = (27'(sh_reg[i]) + 27'sd1) >>> 1;
            if (rnd[i] > 27'sd32767)
            begin
                sat[i] = 16'sh7FFF;
            end
            else if (rnd[i] < -27'sd32768)
            begin
                sat[i] = 16'sh8000;
            end
            else
            begin
                sat[i] = rnd[i][15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                si_reg[i] <= 42'(sh_reg[i]) * 42'(nh_reg[i]);
                oi_reg[i] <= sat[i];
            end
            zeroi_reg <= zeroh_reg;
        end
    end

    // Stage J: output register.
    logic signed [43:0] side_sum;
    logic signed [15:0] ox_reg;
    logic signed [15:0] oy_reg;
    logic signed [15:0] oz_reg;
    status_t            st_reg;

    assign side_sum = 44'(si_reg[0]) + 44'(si_reg[1]) + 44'(si_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zeroi_reg)
            begin
                ox_reg <= '0;
                oy_reg <= '0;
                oz_reg <= '0;
                st_reg <= ST_ZERO;
            end
            else
            begin
                ox_reg <= oi_reg[0];
                oy_reg <= oi_reg[1];
                oz_reg <= oi_reg[2];
                st_reg <= (side_sum > 44'sd0) ? ST_OUTWARD : ST_ABSORBED;
            end
        end
    end

    assign out_x  = ox_reg;
    assign out_y  = oy_reg;
    assign out_z  = oz_reg;
    assign status = st_reg;

endmodule

/* sv/grd_isqrt.sv */
module grd_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] radicand,
    output logic [29:0] root
);
    import grd_pkg::*;

    // The radicand is taken as radicand * 2^28; one root bit per stage.
    logic [29:0] q_reg   [SQ_STEPS];
    logic [32:0] rem_reg [SQ_STEPS];
    logic [31:0] rad_reg [SQ_STEPS];

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
        logic [29:0] q_in;
        logic [32:0] rem_in;
        logic [31:0] rad_in;
        logic [32:0] cur;
        logic [32:0] trial;
        logic        take;

        if (g == 0) begin : g_first
            assign q_in   = '0;
            assign rem_in = '0;
            assign rad_in = radicand;
        end else begin : g_rest
            assign q_in   = q_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign rad_in = rad_reg[g-1];
        end

        assign cur   = {rem_in[30:0], rad_in[31:30]};
        assign trial = {1'b0, q_in, 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[g] <= {rad_in[29:0], 2'b00};
                q_reg[g]   <= {q_in[28:0], take};
                rem_reg[g] <= take ? (cur - trial) : cur;
            end
        end
    end

    assign root = q_reg[SQ_STEPS-1];

endmodule

/* sv/grd_div.sv */
module grd_div (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] mag,
    input  logic [29:0] m,
    output logic [14:0] quot
);
    import grd_pkg::*;

    // Computes (mag * 2^28 + m/2) / m, one quotient bit per stage.
    logic [43:0] num;
    logic [29:0] rem_reg [DIV_STEPS+1];
    logic [14:0] low_reg [DIV_STEPS+1];
    logic [29:0] m_reg   [DIV_STEPS+1];

    assign num = {mag, 28'd0} + {15'd0, m[29:1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, num[43:15]};
            low_reg[0] <= num[14:0];
            m_reg[0]   <= m;
        end
    end

    for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_step
        logic [30:0] cur;
        logic        take;

        assign cur  = {rem_reg[g-1], low_reg[g-1][14]};
        assign take = (cur >= {1'b0, m_reg[g-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= take ? 30'(cur - {1'b0, m_reg[g-1]}) : cur[29:0];
                low_reg[g] <= {low_reg[g-1][13:0], take};
                m_reg[g]   <= m_reg[g-1];
            end
        end
    end

    assign quot = low_reg[DIV_STEPS];

endmodule
